// ===== src/scr_pkg.sv =====
// ----------------------------------------------------------------------------
// scr_pkg
// Shared types, constants and the brightness-similarity table of the SUSAN
// corner response pipeline.
// ----------------------------------------------------------------------------
package scr_pkg;

  localparam int BRIGHT_THRESH = 20;
  localparam int MAX_HEIGHT    = 1024;
  localparam int ROW_W         = 10;
  localparam int POS_W         = 10;
  localparam int WIN           = 7;
  localparam int WIN_MID       = 3;
  localparam int SIM_W         = 7;
  localparam int AREA_W        = 12;
  localparam int MOM_W         = 14;

  localparam int HALF_SPAN [WIN] = '{1, 2, 3, 3, 3, 2, 1};

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_GEO_THRESH   = 2'd2,
    REG_RAY_THRESH   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } in_word_t;

  typedef struct packed {
    logic [POS_W-1:0]  column;
    logic [POS_W-1:0]  row;
    logic [AREA_W-1:0] corner_response;
  } out_word_t;

  // per-stage control travelling with each word
  typedef struct packed {
    logic             valid;
    logic             emit;
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] row;
  } scr_ctl_t;

  typedef logic [WIN-1:0][WIN-1:0][7:0]       win_t;
  typedef logic [WIN-1:0][WIN-1:0][SIM_W-1:0] sim_arr_t;
  typedef logic [255:0][SIM_W-1:0]            sim_rom_t;

  function automatic logic in_mask(input int r, input int c);
    int dc;
    dc = (c > WIN_MID) ? c - WIN_MID : WIN_MID - c;
    return (dc <= HALF_SPAN[r]) && !(r == WIN_MID && c == WIN_MID);
  endfunction

  // shift-subtract division, elaboration time only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] dv);
    logic [63:0] q;
    logic [63:0] rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], n[i]};
      if (rem >= dv) begin
        rem  = rem - dv;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // 100*exp(-(d/t)^6) in Q30 fixed point
  function automatic logic [SIM_W-1:0] sim_value(input logic [63:0] d);
    logic [63:0] t, t6, d6, q, r, y, term, e, v;
    t    = 64'(BRIGHT_THRESH);
    t6   = t * t * t;
    t6   = t6 * t6;
    d6   = d * d * d;
    d6   = d6 * d6;
    if (d6 * 64'd1000 > t6 * 64'd4606) begin
      return '0;
    end
    q = udiv64(d6, t6);
    r = d6 - q * t6;
    for (int i = 0; i < 30; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= t6) begin
        r    = r - t6;
        q[0] = 1'b1;
      end
    end
    y    = q >> 3;
    term = 64'd1 << 30;
    e    = 64'd1 << 30;
    for (int i = 1; i <= 12; i++) begin
      term = udiv64((term * y) >> 30, 64'(i));
      if (i % 2 == 1) begin
        e = e - term;
      end else begin
        e = e + term;
      end
    end
    for (int i = 0; i < 3; i++) begin
      e = (e * e) >> 30;
    end
    v = (64'd100 * e) >> 30;
    return (v > 64'd100) ? SIM_W'(100) : SIM_W'(v);
  endfunction

  function automatic sim_rom_t build_sim_rom();
    sim_rom_t tab;
    for (int d = 0; d < 256; d++) begin
      tab[d] = sim_value(64'(d));
    end
    return tab;
  endfunction

  localparam sim_rom_t SIM_ROM = build_sim_rom();

endpackage

// ===== src/scr_line_buf.sv =====
// ----------------------------------------------------------------------------
// scr_line_buf
// Six line stores packed in one memory word per column, and the 7x7 window.
// Columns not yet written since reset read as zero through a fill mark.
// ----------------------------------------------------------------------------
module scr_line_buf #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  scr_pkg::scr_ctl_t            in_ctl,
  input  logic [7:0]                   in_pixel,
  input  logic [$clog2(MAX_WIDTH)-1:0] in_addr,
  output scr_pkg::scr_ctl_t            win_ctl,
  output scr_pkg::win_t                win_pixels
);

  localparam int CW = $clog2(MAX_WIDTH);

  typedef logic [5:0][7:0] lb_word_t;

  lb_word_t          mem [MAX_WIDTH];
  lb_word_t          rd_q_r;
  lb_word_t          byp_data_r;
  logic              byp_r;
  logic              rd_zero_r;
  logic [CW:0]       fill_r;
  scr_pkg::scr_ctl_t s1_ctl_r;
  logic [7:0]        s1_pix_r;
  logic [CW-1:0]     s1_addr_r;
  scr_pkg::scr_ctl_t s2_ctl_r;
  scr_pkg::win_t     window_r;
  scr_pkg::win_t     window_nxt;
  lb_word_t          col_word;
  lb_word_t          wr_word;
  logic [6:0][7:0]   column;

  // the word written back this cycle may be the one just read
  assign col_word = byp_r ? byp_data_r : (rd_zero_r ? '0 : rd_q_r);

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      column[k] = col_word[k];
    end
    column[6] = s1_pix_r;
    for (int k = 0; k < 6; k++) begin
      wr_word[k] = column[k + 1];
    end
    for (int r = 0; r < 7; r++) begin
      for (int c = 0; c < 6; c++) begin
        window_nxt[r][c] = window_r[r][c + 1];
      end
      window_nxt[r][6] = column[r];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_q_r <= mem[in_addr];
      if (s1_ctl_r.valid) begin
        mem[s1_addr_r] <= wr_word;
      end
    end
  end

  // written columns always form a prefix from column 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r.valid <= 1'b0;
      s2_ctl_r.valid <= 1'b0;
      byp_r          <= 1'b0;
      rd_zero_r      <= 1'b1;
      fill_r         <= '0;
    end else if (adv) begin
      s1_ctl_r   <= in_ctl;
      s1_pix_r   <= in_pixel;
      s1_addr_r  <= in_addr;
      byp_r      <= s1_ctl_r.valid && (s1_addr_r == in_addr);
      byp_data_r <= wr_word;
      rd_zero_r  <= ({1'b0, in_addr} >= fill_r);
      if (s1_ctl_r.valid && ({1'b0, s1_addr_r} >= fill_r)) begin
        fill_r <= {1'b0, s1_addr_r} + 1'b1;
      end
      s2_ctl_r   <= s1_ctl_r;
      if (s1_ctl_r.valid) begin
        window_r <= window_nxt;
      end
    end
  end

  assign win_ctl    = s2_ctl_r;
  assign win_pixels = window_r;

endmodule

// ===== src/scr_usan.sv =====
// ----------------------------------------------------------------------------
// scr_usan
// Similarity lookups over the window, then USAN area and first moments
// through a two-level registered adder tree.
// ----------------------------------------------------------------------------
module scr_usan (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  scr_pkg::scr_ctl_t                   in_ctl,
  input  scr_pkg::win_t                       in_win,
  output scr_pkg::scr_ctl_t                   mom_ctl,
  output scr_pkg::sim_arr_t                   mom_sims,
  output logic [scr_pkg::AREA_W-1:0]          mom_n,
  output logic signed [scr_pkg::MOM_W-1:0]    mom_x,
  output logic signed [scr_pkg::MOM_W-1:0]    mom_y
);

  scr_pkg::scr_ctl_t  s3_ctl_r, s4_ctl_r, s5_ctl_r;
  scr_pkg::sim_arr_t  s3_sims_r, s4_sims_r, s5_sims_r;
  scr_pkg::sim_arr_t  sims_nxt;
  logic [9:0]         rn_r  [7];
  logic signed [11:0] rx_r  [7];
  logic [9:0]         rn_nxt[7];
  logic signed [11:0] rx_nxt[7];
  logic [scr_pkg::AREA_W-1:0]       n_r, n_nxt;
  logic signed [scr_pkg::MOM_W-1:0] x_r, y_r, x_nxt, y_nxt;
  logic [7:0]         centre;
  logic [7:0]         diff;

  always_comb begin
    centre = in_win[scr_pkg::WIN_MID][scr_pkg::WIN_MID];
    diff   = '0;
    for (int r = 0; r < 7; r++) begin
      for (int c = 0; c < 7; c++) begin
        diff = (centre > in_win[r][c]) ? centre - in_win[r][c] : in_win[r][c] - centre;
        sims_nxt[r][c] = scr_pkg::SIM_ROM[diff];
      end
    end
  end

  // per-row partial area and x moment
  always_comb begin
    for (int r = 0; r < 7; r++) begin
      rn_nxt[r] = '0;
      rx_nxt[r] = '0;
      for (int c = 0; c < 7; c++) begin
        if (scr_pkg::in_mask(r, c)) begin
          rn_nxt[r] = rn_nxt[r] + 10'(s3_sims_r[r][c]);
          rx_nxt[r] = rx_nxt[r] + 12'((c - 3) * int'(s3_sims_r[r][c]));
        end
      end
    end
  end

  always_comb begin
    n_nxt = scr_pkg::AREA_W'(100);
    x_nxt = '0;
    y_nxt = '0;
    for (int r = 0; r < 7; r++) begin
      n_nxt = n_nxt + scr_pkg::AREA_W'(rn_r[r]);
      x_nxt = x_nxt + scr_pkg::MOM_W'(rx_r[r]);
      y_nxt = y_nxt + scr_pkg::MOM_W'((r - 3) * int'(rn_r[r]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_ctl_r.valid <= 1'b0;
      s4_ctl_r.valid <= 1'b0;
      s5_ctl_r.valid <= 1'b0;
    end else if (adv) begin
      s3_ctl_r       <= in_ctl;
      s3_ctl_r.valid <= in_ctl.valid && in_ctl.emit;
      s3_sims_r      <= sims_nxt;
      s4_ctl_r       <= s3_ctl_r;
      s4_sims_r      <= s3_sims_r;
      rn_r           <= rn_nxt;
      rx_r           <= rx_nxt;
      s5_ctl_r       <= s4_ctl_r;
      s5_sims_r      <= s4_sims_r;
      n_r            <= n_nxt;
      x_r            <= x_nxt;
      y_r            <= y_nxt;
    end
  end

  assign mom_ctl  = s5_ctl_r;
  assign mom_sims = s5_sims_r;
  assign mom_n    = n_r;
  assign mom_x    = x_r;
  assign mom_y    = y_r;

endmodule

// ===== src/scr_ray.sv =====
// ----------------------------------------------------------------------------
// scr_ray
// Geometric and centroid tests, ray position rounding, ray similarity sum
// and the output register.
// ----------------------------------------------------------------------------
module scr_ray (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             adv,
  input  scr_pkg::scr_ctl_t                in_ctl,
  input  scr_pkg::sim_arr_t                in_sims,
  input  logic [scr_pkg::AREA_W-1:0]       in_n,
  input  logic signed [scr_pkg::MOM_W-1:0] in_x,
  input  logic signed [scr_pkg::MOM_W-1:0] in_y,
  input  logic [11:0]                      geo_thresh,
  input  logic [8:0]                       ray_thresh,
  output logic                             out_valid,
  output scr_pkg::out_word_t               out_data
);

  localparam int AW = scr_pkg::MOM_W - 1;

  scr_pkg::scr_ctl_t          s6_ctl_r, s7_ctl_r, s8_ctl_r;
  scr_pkg::sim_arr_t          s6_sims_r, s7_sims_r, s8_sims_r;
  logic [scr_pkg::AREA_W-1:0] s6_n_r, s7_n_r, s8_n_r;
  logic signed [scr_pkg::MOM_W-1:0] s6_x_r, s6_y_r;
  logic [24:0] xx_r, yy_r;
  logic [22:0] nh_r;
  logic        nlt_r;
  logic        s7_keep_r, s8_keep_r;
  logic        dir_r;
  logic [AW-1:0] min_abs_r, maj_abs_r;
  logic        min_neg_r, maj_neg_r;
  logic [2:0]  rix_r [3];
  logic [2:0]  cix_r [3];
  logic [2:0]  rix_nxt [3];
  logic [2:0]  cix_nxt [3];
  logic        out_valid_r;
  scr_pkg::out_word_t out_data_r;

  logic signed [scr_pkg::MOM_W-1:0] minor, major;
  logic [AW-1:0] min_abs, maj_abs;
  logic [15:0]   num2, den;
  logic [1:0]    q;
  logic [2:0]    minor_pos, major_pos;
  logic [8:0]    ray_sum;

  always_comb begin
    minor   = (yy_r < xx_r) ? s6_y_r : s6_x_r;
    major   = (yy_r < xx_r) ? s6_x_r : s6_y_r;
    min_abs = AW'(minor[scr_pkg::MOM_W-1] ? -minor : minor);
    maj_abs = AW'(major[scr_pkg::MOM_W-1] ? -major : major);
    if (maj_abs == '0) begin
      maj_abs = AW'(1);
    end
  end

  // round(k*minor/major), halves away from zero: count of 2|a| >= (2t-1)|b|
  always_comb begin
    num2      = '0;
    den       = 16'(maj_abs_r);
    q         = '0;
    minor_pos = '0;
    major_pos = '0;
    for (int k = 1; k <= 3; k++) begin
      num2 = 16'(2 * k) * 16'(min_abs_r);
      q    = 2'(num2 >= den) + 2'(num2 >= 16'(3) * den) + 2'(num2 >= 16'(5) * den);
      minor_pos = min_neg_r ? 3'(3) - 3'(q) : 3'(3) + 3'(q);
      major_pos = maj_neg_r ? 3'(3 - k) : 3'(3 + k);
      rix_nxt[k - 1] = dir_r ? minor_pos : major_pos;
      cix_nxt[k - 1] = dir_r ? major_pos : minor_pos;
    end
  end

  always_comb begin
    ray_sum = '0;
    for (int k = 0; k < 3; k++) begin
      ray_sum = ray_sum + 9'(s8_sims_r[rix_r[k]][cix_r[k]]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_ctl_r.valid <= 1'b0;
      s7_ctl_r.valid <= 1'b0;
      s8_ctl_r.valid <= 1'b0;
      out_valid_r    <= 1'b0;
    end else if (adv) begin
      s6_ctl_r  <= in_ctl;
      s6_sims_r <= in_sims;
      s6_n_r    <= in_n;
      s6_x_r    <= in_x;
      s6_y_r    <= in_y;
      xx_r      <= 25'(28'(in_x) * 28'(in_x));
      yy_r      <= 25'(28'(in_y) * 28'(in_y));
      nh_r      <= 23'((24'(in_n) * 24'(in_n)) >> 1);
      nlt_r     <= in_n < geo_thresh;

      s7_ctl_r  <= s6_ctl_r;
      s7_sims_r <= s6_sims_r;
      s7_n_r    <= s6_n_r;
      s7_keep_r <= nlt_r && ((26'(xx_r) + 26'(yy_r)) > 26'(nh_r));
      dir_r     <= yy_r < xx_r;
      min_abs_r <= min_abs;
      maj_abs_r <= maj_abs;
      min_neg_r <= minor[scr_pkg::MOM_W-1];
      maj_neg_r <= major[scr_pkg::MOM_W-1];

      s8_ctl_r  <= s7_ctl_r;
      s8_sims_r <= s7_sims_r;
      s8_n_r    <= s7_n_r;
      s8_keep_r <= s7_keep_r;
      rix_r     <= rix_nxt;
      cix_r     <= cix_nxt;

      out_valid_r               <= s8_ctl_r.valid;
      out_data_r.column         <= s8_ctl_r.column;
      out_data_r.row            <= s8_ctl_r.row;
      out_data_r.corner_response <= (s8_keep_r && ray_sum > ray_thresh) ?
                                    geo_thresh - s8_n_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/susan_corner_response.sv =====
// ----------------------------------------------------------------------------
// susan_corner_response
// SUSAN corner response over a 37-pixel circular mask, one pixel a cycle unless stalled.
// ----------------------------------------------------------------------------
//  channel  direction  word / fields                         handshake
//  in_      input      pixel, frame_start                    in_valid / in_stall
//  out_     output     column, row, corner_response          out_valid / out_stall
//  cfg_     input      cfg_index, cfg_wr_data                cfg_wr_en
//
//  One pixel word is taken every cycle unless out_stall freezes the pipeline;
//  the pixel completing a window passes nine register stages (line store
//  read, window, lookups, two adder levels, squares, tests, rounding, ray sum
//  and output register) before its response appears on out_.
//  Reset clears pipeline valids and counters and loads config defaults; line store
//  columns not yet written since reset read as zero through a fill mark.
//  While out_valid is high, a held out_stall freezes the whole pipeline and raises in_stall.
// ----------------------------------------------------------------------------
module susan_corner_response #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  scr_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output scr_pkg::out_word_t out_data,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_wr_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = (CW + 1 > 11) ? CW + 1 : 11;

  logic [10:0]   frame_width_r, frame_height_r;
  logic [11:0]   geo_thresh_r;
  logic [8:0]    ray_thresh_r;
  logic [CW-1:0] col_cnt_r, col_cnt_nxt;
  logic [scr_pkg::ROW_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [CW-1:0] col_cur;
  logic [scr_pkg::ROW_W-1:0] row_cur;
  logic [EW-1:0] eff_w;
  logic [10:0]   eff_h;
  logic          adv, in_acc;
  scr_pkg::scr_ctl_t in_ctl, win_ctl, mom_ctl;
  scr_pkg::win_t     win_pixels;
  scr_pkg::sim_arr_t mom_sims;
  logic [scr_pkg::AREA_W-1:0]       mom_n;
  logic signed [scr_pkg::MOM_W-1:0] mom_x, mom_y;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign in_acc   = in_valid && adv;

  always_comb begin
    eff_w = (EW'(frame_width_r) > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : EW'(frame_width_r);
    if (eff_w == '0) begin
      eff_w = EW'(1);
    end
    eff_h = (frame_height_r > 11'(scr_pkg::MAX_HEIGHT)) ? 11'(scr_pkg::MAX_HEIGHT)
                                                          : frame_height_r;
    if (eff_h == '0) begin
      eff_h = 11'(1);
    end
    col_cur = in_data.frame_start ? '0 : col_cnt_r;
    row_cur = in_data.frame_start ? '0 : row_cnt_r;
    if (EW'(col_cur) + EW'(1) >= eff_w) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = (11'(row_cur) + 11'(1) >= eff_h) ? '0 : row_cur + 1'b1;
    end else begin
      col_cnt_nxt = col_cur + 1'b1;
      row_cnt_nxt = row_cur;
    end
    in_ctl.valid  = in_acc;
    in_ctl.emit   = (col_cur >= CW'(6)) && (row_cur >= scr_pkg::ROW_W'(6));
    in_ctl.column = scr_pkg::POS_W'(col_cur - CW'(3));
    in_ctl.row    = scr_pkg::POS_W'(row_cur - scr_pkg::ROW_W'(3));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (in_acc) begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= 11'd640;
      frame_height_r <= 11'd480;
      geo_thresh_r   <= 12'd1850;
      ray_thresh_r   <= 9'd290;
    end else if (cfg_wr_en) begin
      unique case (scr_pkg::cfg_reg_t'(cfg_index))
        scr_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_wr_data[10:0];
        scr_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_wr_data[10:0];
        scr_pkg::REG_GEO_THRESH:   geo_thresh_r   <= cfg_wr_data;
        scr_pkg::REG_RAY_THRESH:   ray_thresh_r   <= cfg_wr_data[8:0];
        default: ;
      endcase
    end
  end

  scr_line_buf #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_ctl    (in_ctl),
    .in_pixel  (in_data.pixel),
    .in_addr   (col_cur),
    .win_ctl   (win_ctl),
    .win_pixels(win_pixels)
  );

  scr_usan u_usan (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_ctl  (win_ctl),
    .in_win  (win_pixels),
    .mom_ctl (mom_ctl),
    .mom_sims(mom_sims),
    .mom_n   (mom_n),
    .mom_x   (mom_x),
    .mom_y   (mom_y)
  );

  scr_ray u_ray (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_ctl    (mom_ctl),
    .in_sims   (mom_sims),
    .in_n      (mom_n),
    .in_x      (mom_x),
    .in_y      (mom_y),
    .geo_thresh(geo_thresh_r),
    .ray_thresh(ray_thresh_r),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== tb/susan_score_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// susan_score_checker
// Watches the pixel, response and register ports of the corner response
// block, works out the response due for each accepted pixel that completes
// a window, and compares each response word field by field in arrival order.
// ----------------------------------------------------------------------------
module susan_score_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  scr_pkg::in_word_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  scr_pkg::out_word_t out_data,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_wr_data,
  output int                 fail_count,
  output int                 pending
);

  localparam int LINE_DEPTH = 1024;

  logic [7:0]  sim_lut [256];
  logic [7:0]  line_mem [6][LINE_DEPTH];
  logic [7:0]  win_pix [7][7];
  int unsigned col_pos, row_pos;
  logic [10:0] width_reg, height_reg;
  logic [11:0] geo_reg;
  logic [8:0]  ray_reg;
  scr_pkg::out_word_t resp_q [$];

  assign pending = resp_q.size();

  function automatic logic [7:0] similarity(input longint unsigned d);
    longint unsigned t6, d6, q, r, y, term, e, v;
    t6 = 64'(scr_pkg::BRIGHT_THRESH) ** 6;
    d6 = d * d * d;
    d6 = d6 * d6;
    if (d6 * 1000 > t6 * 4606) return 8'd0;
    q = d6 / t6;
    r = d6 % t6;
    for (int i = 0; i < 30; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= t6) begin
        r = r - t6;
        q = q | 1;
      end
    end
    y = q >> 3;
    term = 64'd1 << 30;
    e = 64'd1 << 30;
    for (int i = 1; i <= 12; i++) begin
      term = ((term * y) >> 30) / longint'(i);
      if (i % 2 == 1) e = e - term;
      else e = e + term;
    end
    for (int i = 0; i < 3; i++) e = (e * e) >> 30;
    v = (100 * e) >> 30;
    return (v > 100) ? 8'd100 : 8'(v);
  endfunction

  function automatic longint near_ratio(input longint num, input longint den);
    longint a, q;
    a = (num < 0) ? -num : num;
    if (den <= 0) den = 1;
    q = (2 * a + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic int unsigned sim_near(input int r, input int c, input int unsigned ctr);
    int unsigned p, d;
    r = (r < 0) ? 0 : ((r > 6) ? 6 : r);
    c = (c < 0) ? 0 : ((c > 6) ? 6 : c);
    p = win_pix[r][c];
    d = (ctr > p) ? ctr - p : p - ctr;
    return sim_lut[d & 255];
  endfunction

  function automatic logic [11:0] score_centre();
    int span [7];
    int unsigned ctr, ray, s;
    longint n, x, y, xx, yy, sgn, ax;
    span = '{1, 2, 3, 3, 3, 2, 1};
    ctr = win_pix[3][3];
    n = 100;
    x = 0;
    y = 0;
    ray = 0;
    for (int r = 0; r < 7; r++) begin
      for (int c = 3 - span[r]; c <= 3 + span[r]; c++) begin
        if (!(r == 3 && c == 3)) begin
          s = sim_near(r, c, ctr);
          n += s;
          x += longint'(c - 3) * s;
          y += longint'(r - 3) * s;
        end
      end
    end
    if (n >= longint'(geo_reg)) return 12'd0;
    xx = x * x;
    yy = y * y;
    if (xx + yy <= (n * n) / 2) return 12'd0;
    if (yy < xx) begin
      ax = (x < 0) ? -x : x;
      sgn = (x < 0) ? -1 : 1;
      for (int k = 1; k <= 3; k++)
        ray += sim_near(3 + int'(near_ratio(k * y, ax)), 3 + int'(k * sgn), ctr);
    end else begin
      ax = (y < 0) ? -y : y;
      sgn = (y < 0) ? -1 : 1;
      for (int k = 1; k <= 3; k++)
        ray += sim_near(3 + int'(k * sgn), 3 + int'(near_ratio(k * x, ax)), ctr);
    end
    if (ray > ray_reg) return 12'(longint'(geo_reg) - n);
    return 12'd0;
  endfunction

  task automatic take_pixel(input scr_pkg::in_word_t w);
    int unsigned eff_w, eff_h, col, row;
    logic [7:0] colv [7];
    scr_pkg::out_word_t exp_w;
    eff_w = (width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg;
    eff_h = (height_reg > scr_pkg::MAX_HEIGHT) ? scr_pkg::MAX_HEIGHT : height_reg;
    if (eff_w == 0) eff_w = 1;
    if (eff_h == 0) eff_h = 1;
    if (w.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    col = (col_pos < LINE_DEPTH) ? col_pos : LINE_DEPTH - 1;
    row = row_pos;
    for (int k = 0; k < 6; k++) colv[k] = line_mem[k][col];
    colv[6] = w.pixel;
    for (int k = 0; k < 6; k++) line_mem[k][col] = colv[k + 1];
    for (int k = 0; k < 7; k++) begin
      for (int j = 0; j < 6; j++) win_pix[k][j] = win_pix[k][j + 1];
      win_pix[k][6] = colv[k];
    end
    if (row >= 6 && col >= 6) begin
      exp_w.column = scr_pkg::POS_W'(col - 3);
      exp_w.row = scr_pkg::POS_W'(row - 3);
      exp_w.corner_response = score_centre();
      resp_q = {resp_q, exp_w};
    end
    if (col + 1 >= eff_w) begin
      col_pos = 0;
      row_pos = (row + 1 >= eff_h) ? 0 : row + 1;
    end else begin
      col_pos = col + 1;
    end
  endtask

  initial begin
    fail_count = 0;
    for (int d = 0; d < 256; d++) sim_lut[d] = similarity(longint'(d));
    for (int k = 0; k < 6; k++)
      for (int j = 0; j < LINE_DEPTH; j++) line_mem[k][j] = '0;
  end

  always @(posedge clk) begin
    scr_pkg::out_word_t want;
    if (!rst_n) begin
      for (int k = 0; k < 7; k++)
        for (int j = 0; j < 7; j++) win_pix[k][j] = '0;
      col_pos = 0;
      row_pos = 0;
      width_reg = 11'd640;
      height_reg = 11'd480;
      geo_reg = 12'd1850;
      ray_reg = 9'd290;
      resp_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (scr_pkg::cfg_reg_t'(cfg_index))
          scr_pkg::REG_FRAME_WIDTH:  width_reg = cfg_wr_data[10:0];
          scr_pkg::REG_FRAME_HEIGHT: height_reg = cfg_wr_data[10:0];
          scr_pkg::REG_GEO_THRESH:   geo_reg = cfg_wr_data;
          scr_pkg::REG_RAY_THRESH:   ray_reg = cfg_wr_data[8:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) take_pixel(in_data);
      if (out_valid && !out_stall) begin
        if (resp_q.size() == 0) begin
          $display("%0t: unexpected response word %p", $time, out_data);
          fail_count++;
        end else begin
          want = resp_q.pop_front();
          if (out_data.column !== want.column) begin
            $display("%0t: column expected %0d actual %0d", $time, want.column,
                     out_data.column);
            fail_count++;
          end
          if (out_data.row !== want.row) begin
            $display("%0t: row expected %0d actual %0d", $time, want.row, out_data.row);
            fail_count++;
          end
          if (out_data.corner_response !== want.corner_response) begin
            $display("%0t: response at (%0d,%0d) expected %0d actual %0d", $time,
                     want.column, want.row, want.corner_response,
                     out_data.corner_response);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb_susan_corner_response.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_susan_corner_response
// Drives pixel frames of several sizes and thresholds into the corner
// response block under random source and sink idling and one long sink
// hold-off; a separate checker predicts and compares every response word.
// ----------------------------------------------------------------------------
module tb_susan_corner_response;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  scr_pkg::in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  scr_pkg::out_word_t out_data;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [11:0] cfg_wr_data = '0;
  int fail_count, pending;
  int src_idle_pct = 0, snk_idle_pct = 0;
  bit hold_request = 0;
  int random_items = 0;

  always #5 clk = ~clk;

  susan_corner_response i_dut (.*);

  susan_score_checker i_checker (.*);

  // sink: random stall, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 0;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < snk_idle_pct);
    end
  end

  task automatic write_reg(input scr_pkg::cfg_reg_t idx, input int val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= 12'(val);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_frame(input int w, input int h, input int geo, input int ray);
    write_reg(scr_pkg::REG_FRAME_WIDTH, w);
    write_reg(scr_pkg::REG_FRAME_HEIGHT, h);
    write_reg(scr_pkg::REG_GEO_THRESH, geo);
    write_reg(scr_pkg::REG_RAY_THRESH, ray);
  endtask

  // source idles cycle by cycle before offering the word
  task automatic send_word(input logic [7:0] pix, input logic fs);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{pixel: pix, frame_start: fs};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // pattern 0 noise, 1 bright quadrant corner, 2 near flat, 3 black/white
  task automatic send_frame(input int w, input int count, input int pattern);
    int cx, ry, c, r, v;
    cx = $urandom_range(2, w - 2);
    ry = $urandom_range(2, 6);
    for (int i = 0; i < count; i++) begin
      c = i % w;
      r = i / w;
      case (pattern)
        0: v = $urandom_range(255);
        1: v = ((c >= cx) && (r >= ry) ? 200 : 40) + $urandom_range(0, 12) - 6;
        2: v = 128 + $urandom_range(0, 30) - 15;
        default: v = ((c >= cx) && (r >= ry)) ^ ($urandom_range(15) == 0) ? 255 : 0;
      endcase
      send_word(8'(v), i == 0);
    end
    in_valid <= 1'b0;
  endtask

  task automatic settle();
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    int w, h, n, mode, target;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: smallest frame, loosest and tightest thresholds
    set_frame(8, 8, 3700, 0);
    send_frame(8, 64, 3);
    settle();
    set_frame(8, 8, 0, 300);
    send_frame(8, 64, 1);
    settle();

    for (mode = 0; mode < 3; mode++) begin
      src_idle_pct = (mode == 0) ? 34 : ((mode == 1) ? 81 : 0);
      snk_idle_pct = (mode == 0) ? 81 : ((mode == 1) ? 34 : 0);
      target = random_items + 60;
      while (random_items < target) begin
        w = $urandom_range(8, 14);
        h = $urandom_range(8, 11);
        set_frame(w, h, ($urandom_range(3) == 0) ? $urandom_range(3700) :
                  $urandom_range(1500, 3700), $urandom_range(300));
        if (random_items == 0) hold_request = 1;
        case ($urandom_range(5))
          0: n = $urandom_range(10, w * h - 1);
          1: n = w * h + $urandom_range(1, 3 * w);
          default: n = w * h;
        endcase
        send_frame(w, n, $urandom_range(3));
        random_items += n;
        settle();
      end
    end

    // widest and tallest register settings, beyond the line store width and the height limit
    set_frame(2047, 8, 3000, 100);
    send_frame(1024, 30, 1);
    settle();
    set_frame(8, 2047, 2500, 200);
    send_frame(8, 70, 0);
    settle();

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== susan_corner_response.f =====
src/scr_pkg.sv
src/scr_line_buf.sv
src/scr_usan.sv
src/scr_ray.sv
src/susan_corner_response.sv
tb/susan_score_checker.sv
tb/tb_susan_corner_response.sv
